### src/dtc_pkg.sv
// ----------------------------------------------------------------------------
// dtc_pkg: damping torque curve shared definitions
// widths, fixed-point shifts, register indexes and pipeline sideband types
// ----------------------------------------------------------------------------
package dtc_pkg;

  localparam int SPEED_W         = 21;
  localparam int MAG_W           = 21;
  localparam int TORQUE_W        = 15;
  localparam int GAIN_W          = 16;
  localparam int SPD_CFG_W       = 20;
  localparam int SPEED_FRAC_BITS = 4;
  localparam int GAIN_FRAC_BITS  = 8;
  localparam int PROD_SHIFT      = SPEED_FRAC_BITS + GAIN_FRAC_BITS;
  localparam int BLEND_BITS      = 16;
  localparam int DIV_STAGES      = BLEND_BITS;
  localparam int LIN_PROD_W      = GAIN_W + MAG_W;
  localparam int KNEE_PROD_W     = GAIN_W + SPD_CFG_W;
  localparam int LIM_SC_W        = TORQUE_W + PROD_SHIFT;
  localparam int SQ_W            = 2 * BLEND_BITS;
  localparam int WEIGHT_W        = BLEND_BITS + 2;
  localparam int SMOOTH_PROD_W   = SQ_W + WEIGHT_W;
  localparam int NUM_PROD_W      = LIM_SC_W + BLEND_BITS;
  localparam int NUM_W           = NUM_PROD_W + 1;
  localparam int BLEND_Q_W       = NUM_W - BLEND_BITS - PROD_SHIFT;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [1:0] REG_LIMIT = 2'd0;
  localparam logic [1:0] REG_GAIN  = 2'd1;
  localparam logic [1:0] REG_KNEE  = 2'd2;
  localparam logic [1:0] REG_SAT   = 2'd3;

  typedef enum logic [1:0] {
    RGN_ZERO,
    RGN_LIN,
    RGN_SAT,
    RGN_BLEND
  } region_e;

  typedef struct packed {
    region_e               region;
    logic [TORQUE_W-1:0]   lin_torque;
  } dtc_side_t;

endpackage

### src/dtc_div.sv
// ----------------------------------------------------------------------------
// dtc_div: pipelined restoring divider for the blend position
// one quotient bit per stage, sideband carried along with each transfer
// ----------------------------------------------------------------------------
module dtc_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [dtc_pkg::SPD_CFG_W-1:0]      span_i,
  input  logic                               valid_i,
  input  logic [dtc_pkg::SPD_CFG_W-1:0]      rem_i,
  input  dtc_pkg::dtc_side_t                 side_i,
  output logic                               valid_o,
  output logic [dtc_pkg::BLEND_BITS-1:0]     quot_o,
  output dtc_pkg::dtc_side_t                 side_o
);
  import dtc_pkg::*;

  logic [DIV_STAGES-1:0] valid_q;
  logic [SPD_CFG_W-1:0]  rem_q  [DIV_STAGES];
  logic [BLEND_BITS-1:0] quot_q [DIV_STAGES];
  dtc_side_t             side_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic                  v_in;
    logic [SPD_CFG_W-1:0]  rem_in;
    logic [BLEND_BITS-1:0] quot_in;
    dtc_side_t             side_in;
    logic [SPD_CFG_W:0]    shifted;
    logic [SPD_CFG_W:0]    diff;
    logic                  fits;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = rem_i;
      assign quot_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quot_in = quot_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign shifted = {rem_in, 1'b0};
    assign fits    = shifted >= {1'b0, span_i};
    assign diff    = shifted - {1'b0, span_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= fits ? diff[SPD_CFG_W-1:0] : shifted[SPD_CFG_W-1:0];
      quot_q[k] <= {quot_in[BLEND_BITS-2:0], fits};
      side_q[k] <= side_in;
    end
  end

  assign valid_o = valid_q[DIV_STAGES-1];
  assign quot_o  = quot_q[DIV_STAGES-1];
  assign side_o  = side_q[DIV_STAGES-1];

endmodule

### src/damping_torque_curve_unit.sv
// ----------------------------------------------------------------------------
// damping_torque_curve_unit: speed-dependent damping torque
// Maps one filtered motor speed to a damping torque magnitude in mA.
//
// Usage:
//   The four curve registers (limit, gain, knee, saturation) are written over
//   the APB port at byte addresses 0, 4, 8 and 12; the user must write them
//   only while no sample is in flight, which the block does not enforce. A
//   sample transfer happens when start is high and busy is low; busy stays
//   low, so a new speed may be given in every cycle. Each result is held on
//   torque_o for one cycle with valid_o high; results come in sample order.
//   Throughput is one sample per cycle; the pipeline holds the 16-stage
//   blend divider plus the input, region, linear torque, three smoothstep
//   multiply and output stages.
//   The receiver cannot stall, so every stage advances in every cycle.
//   Reset clears the registers to zero (damping off) and drops all samples
//   in flight; the first sample may follow right after reset.
// ----------------------------------------------------------------------------
module damping_torque_curve_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dtc_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [dtc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [dtc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [dtc_pkg::SPEED_W-1:0] speed_i,
  output logic                               valid_o,
  output logic [dtc_pkg::TORQUE_W-1:0]       torque_o
);
  import dtc_pkg::*;

  localparam int PIPE_LAT = DIV_STAGES + 7;

  // configuration
  logic [TORQUE_W-1:0]  limit_q;
  logic [GAIN_W-1:0]    gain_q;
  logic [SPD_CFG_W-1:0] knee_q;
  logic [SPD_CFG_W-1:0] sat_q;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign busy   = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
      gain_q  <= '0;
      knee_q  <= '0;
      sat_q   <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_LIMIT: limit_q <= pwdata[TORQUE_W-1:0];
        REG_GAIN:  gain_q  <= pwdata[GAIN_W-1:0];
        REG_KNEE:  knee_q  <= pwdata[SPD_CFG_W-1:0];
        REG_SAT:   sat_q   <= pwdata[SPD_CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LIMIT: prdata = APB_DATA_W'(limit_q);
      REG_GAIN:  prdata = APB_DATA_W'(gain_q);
      REG_KNEE:  prdata = APB_DATA_W'(knee_q);
      REG_SAT:   prdata = APB_DATA_W'(sat_q);
    endcase
  end

  // values derived from the curve registers
  logic [SPD_CFG_W-1:0]   span_q;
  logic                   curve_ok_q;
  logic                   enable_q;
  logic [KNEE_PROD_W-1:0] knee_prod_q;
  logic [LIM_SC_W-1:0]    lim_sc;
  logic [LIM_SC_W-1:0]    knee_t_q;
  logic [LIM_SC_W-1:0]    rise_q;

  assign lim_sc = {limit_q, PROD_SHIFT'(0)};

  always_ff @(posedge clk_i) begin
    span_q      <= sat_q - knee_q;
    curve_ok_q  <= sat_q > knee_q;
    enable_q    <= (limit_q != '0) && (gain_q != '0);
    knee_prod_q <= gain_q * knee_q;
    knee_t_q    <= (knee_prod_q > KNEE_PROD_W'(lim_sc)) ? lim_sc
                                                       : knee_prod_q[LIM_SC_W-1:0];
    rise_q      <= lim_sc - knee_t_q;
  end

  // stage 1: magnitude
  logic             s1_valid_q;
  logic [MAG_W-1:0] s1_mag_q;
  logic [MAG_W-1:0] mag_d;

  assign mag_d = speed_i[SPEED_W-1] ? MAG_W'(~speed_i + 1'b1) : MAG_W'(speed_i);

  // stage 2: linear product and region
  logic                  s2_valid_q;
  logic [LIN_PROD_W-1:0] s2_prod_q;
  region_e               s2_region_q;
  logic [SPD_CFG_W-1:0]  s2_dist_q;
  region_e               region_d;

  always_comb begin
    priority if (!enable_q) begin
      region_d = RGN_ZERO;
    end else if (s1_mag_q <= MAG_W'(knee_q) || !curve_ok_q) begin
      region_d = RGN_LIN;
    end else if (s1_mag_q >= MAG_W'(sat_q)) begin
      region_d = RGN_SAT;
    end else begin
      region_d = RGN_BLEND;
    end
  end

  // stage 3: linear torque, divider feed
  logic                  s3_valid_q;
  logic [SPD_CFG_W-1:0]  s3_dist_q;
  dtc_side_t             s3_side_q;
  logic [LIN_PROD_W-1:0] prod_sh;
  logic [TORQUE_W-1:0]   lin_d;

  assign prod_sh = s2_prod_q >> PROD_SHIFT;
  assign lin_d   = (prod_sh > LIN_PROD_W'(limit_q)) ? limit_q : prod_sh[TORQUE_W-1:0];

  // blend position
  logic                  dv_valid;
  logic [BLEND_BITS-1:0] dv_t;
  dtc_side_t             dv_side;

  dtc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .span_i  (span_q),
    .valid_i (s3_valid_q),
    .rem_i   (s3_dist_q),
    .side_i  (s3_side_q),
    .valid_o (dv_valid),
    .quot_o  (dv_t),
    .side_o  (dv_side)
  );

  // stage 4..6: smoothstep and blend product
  logic                     s4_valid_q;
  logic [SQ_W-1:0]          s4_sq_q;
  logic [BLEND_BITS-1:0]    s4_t_q;
  dtc_side_t                s4_side_q;
  logic                     s5_valid_q;
  logic [BLEND_BITS-1:0]    s5_s_q;
  dtc_side_t                s5_side_q;
  logic                     s6_valid_q;
  logic [NUM_PROD_W-1:0]    s6_prod_q;
  dtc_side_t                s6_side_q;
  logic [WEIGHT_W-1:0]      weight;
  logic [SMOOTH_PROD_W-1:0] smooth_prod;

  assign weight      = WEIGHT_W'(3 << BLEND_BITS) - {1'b0, s4_t_q, 1'b0};
  assign smooth_prod = s4_sq_q * weight;

  // output stage
  logic                  out_valid_q;
  logic [TORQUE_W-1:0]   torque_q;
  logic [NUM_W-1:0]      num;
  logic [BLEND_Q_W-1:0]  blend_raw;
  logic [TORQUE_W-1:0]   blend_t;
  logic [TORQUE_W-1:0]   torque_d;

  assign num       = {1'b0, knee_t_q, BLEND_BITS'(0)} + NUM_W'(s6_prod_q);
  assign blend_raw = BLEND_Q_W'(num >> (BLEND_BITS + PROD_SHIFT));
  assign blend_t   = (blend_raw > BLEND_Q_W'(limit_q)) ? limit_q
                                                        : blend_raw[TORQUE_W-1:0];

  always_comb begin
    unique case (s6_side_q.region)
      RGN_ZERO:  torque_d = '0;
      RGN_LIN:   torque_d = s6_side_q.lin_torque;
      RGN_SAT:   torque_d = limit_q;
      RGN_BLEND: torque_d = blend_t;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      s6_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= start & ~busy;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= dv_valid;
      s5_valid_q  <= s4_valid_q;
      s6_valid_q  <= s5_valid_q;
      out_valid_q <= s6_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_mag_q             <= mag_d;
    s2_prod_q            <= gain_q * s1_mag_q;
    s2_region_q          <= region_d;
    s2_dist_q            <= (region_d == RGN_BLEND) ? SPD_CFG_W'(s1_mag_q - MAG_W'(knee_q))
                                                    : '0;
    s3_dist_q            <= s2_dist_q;
    s3_side_q.region     <= s2_region_q;
    s3_side_q.lin_torque <= lin_d;
    s4_sq_q              <= dv_t * dv_t;
    s4_t_q               <= dv_t;
    s4_side_q            <= dv_side;
    s5_s_q               <= smooth_prod[SQ_W +: BLEND_BITS];
    s5_side_q            <= s4_side_q;
    s6_prod_q            <= rise_q * s5_s_q;
    s6_side_q            <= s5_side_q;
    torque_q             <= torque_d;
  end

  assign valid_o  = out_valid_q;
  assign torque_o = torque_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##PIPE_LAT valid_o)
    else $error("result missing after sample transfer");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, PIPE_LAT))
    else $error("result without matching sample transfer");

  a_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> torque_o <= limit_q)
    else $error("torque above limit");

  a_disabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (limit_q == '0 || gain_q == '0)) |-> torque_o == '0)
    else $error("torque nonzero while damping disabled");

endmodule
